// ===== hdl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/vt4_pkg.sv =====
// -----------------------------------------------------------------------------
// vt4_pkg
// shared types and constants of the 4x4 vertex transform
// -----------------------------------------------------------------------------
package vt4_pkg;

   localparam int DIM       = 4;
   localparam int ELEMS     = DIM * DIM;
   localparam int IDX_W     = 4;
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int FRAC_BITS = 16;
   localparam int SHIFT_W   = SUM_W - FRAC_BITS;

   localparam logic signed [WORD_W-1:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XFORM = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type [DIM-1:0] vec4_type;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] elem_index;
      word_type         elem_value;
      word_type         vec_x;
      word_type         vec_y;
      word_type         vec_z;
      word_type         vec_w;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
      logic     saturated;
   } rsp_type;

   // what one lane hands to the merge stage
   typedef struct packed {
      word_type value;
      logic     clip;
   } lane_res_type;

   typedef lane_res_type [DIM-1:0] lane_res_vec_type;

endpackage

// ===== hdl/vt4_lane.sv =====
// -----------------------------------------------------------------------------
// vt4_lane
// one matrix row times the vector: multiply, sum, floor shift and saturate
// -----------------------------------------------------------------------------
module vt4_lane (
   input  logic                  clock,
   input  logic                  en,
   input  vt4_pkg::vec4_type     row,
   input  vt4_pkg::vec4_type     vec,
   output vt4_pkg::lane_res_type res
);
   import vt4_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff [DIM];
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SHIFT_W-1:0] shifted;
   logic                      over;
   logic                      under;
   lane_res_type              res_in;
   lane_res_type              res_ff;

   // stage 1: four independent products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < DIM; c++) begin
            prod_ff[c] <= $signed(row[c]) * $signed(vec[c]);
         end
      end
   end

   // stage 2: exact sum, two guard bits so it never wraps
   always_comb begin
      sum_in = '0;
      for (int c = 0; c < DIM; c++) begin
         sum_in = sum_in + SUM_W'(prod_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   // stage 3: arithmetic shift is floor, then clip to 32 bits
   assign shifted = sum_ff[SUM_W-1:FRAC_BITS];
   assign over    = !shifted[SHIFT_W-1] && (|shifted[SHIFT_W-2:WORD_W-1]);
   assign under   = shifted[SHIFT_W-1] && !(&shifted[SHIFT_W-2:WORD_W-1]);

   always_comb begin
      res_in.clip = over | under;
      if (over) begin
         res_in.value = WORD_MAX;
      end else if (under) begin
         res_in.value = WORD_MIN;
      end else begin
         res_in.value = shifted[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ===== hdl/vt4_merge.sv =====
// -----------------------------------------------------------------------------
// vt4_merge
// gathers the four lane results into one response, with output skid buffer
// -----------------------------------------------------------------------------
module vt4_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vt4_pkg::lane_res_vec_type lanes,
   output logic                      skid_full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output vt4_pkg::rsp_type          rsp_payload
);
   import vt4_pkg::*;

   rsp_type merged;
   rsp_type head_ff;
   rsp_type skid_ff;
   logic    head_valid_ff;
   logic    skid_valid_ff;
   logic    take;

   always_comb begin
      merged.out_x     = lanes[0].value;
      merged.out_y     = lanes[1].value;
      merged.out_z     = lanes[2].value;
      merged.out_w     = lanes[3].value;
      merged.saturated = lanes[0].clip | lanes[1].clip | lanes[2].clip | lanes[3].clip;
   end

   assign take = head_valid_ff & ~rsp_stall;

   // push only arrives while the skid entry is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            head_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            head_valid_ff <= push;
            head_ff       <= merged;
         end
      end else if (!head_valid_ff) begin
         head_valid_ff <= push;
         head_ff       <= merged;
      end else if (push) begin
         skid_ff       <= merged;
         skid_valid_ff <= 1'b1;
      end
   end

   assign skid_full   = skid_valid_ff;
   assign rsp_valid   = head_valid_ff;
   assign rsp_payload = head_ff;

endmodule

// ===== hdl/vertex_transform_4x4.sv =====
// -----------------------------------------------------------------------------
// vertex_transform_4x4
// 4x4 matrix times 4-component vector in signed Q16.16
// -----------------------------------------------------------------------------
// The block holds a column-major 4x4 matrix (element i at row i%4, column i/4),
// identity after reset. A load request (mode 0) writes one element in the cycle
// it is accepted and gives no response. A transform request (mode 1) gives one
// response with the four row dot products, each floor-shifted right by 16 and
// saturated to 32 bits; saturated flags any clipped component. Four row lanes
// run side by side, so one request is taken every cycle while the output side
// keeps up: a transform sees the matrix as it stands when it is accepted. Its
// products are captured at the edge that accepts it, then the sum, clip and
// output registers follow in that order, and the response is taken from the
// output register. The three-stage lane pipeline plus the head of a two-entry
// output buffer lie on that path; req_stall rises only when the output buffer
// is full.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_transform_4x4 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vt4_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vt4_pkg::rsp_type rsp_payload
);
   import vt4_pkg::*;

   // matrix registers, read at fixed places by the lanes
   word_type         matrix_ff [ELEMS];
   vec4_type         rows [DIM];
   vec4_type         vec;
   lane_res_vec_type lane_res;

   logic accept;
   logic accept_load;
   logic accept_xform;
   logic en;
   logic skid_full;
   logic p1_valid_ff;
   logic p2_valid_ff;
   logic p3_valid_ff;

   // pipeline moves whenever the output buffer has room
   assign en        = ~skid_full;
   assign req_stall = skid_full;

   assign accept       = req_valid & ~req_stall;
   assign accept_load  = accept & (req_payload.mode == MODE_LOAD);
   assign accept_xform = accept & (req_payload.mode == MODE_XFORM);

   // element writes, identity on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEMS; i++) begin
            matrix_ff[i] <= (i % (DIM + 1) == 0) ? ONE_Q16 : '0;
         end
      end else if (accept_load) begin
         matrix_ff[req_payload.elem_index] <= req_payload.elem_value;
      end
   end

   // valid bits travelling alongside the lane stages
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= accept_xform;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   assign vec[0] = req_payload.vec_x;
   assign vec[1] = req_payload.vec_y;
   assign vec[2] = req_payload.vec_z;
   assign vec[3] = req_payload.vec_w;

   // one lane per matrix row
   for (genvar r = 0; r < DIM; r++) begin : g_lane
      for (genvar c = 0; c < DIM; c++) begin : g_col
         assign rows[r][c] = matrix_ff[r + DIM * c];
      end

      vt4_lane u_lane (
         .clock (clock),
         .en    (en),
         .row   (rows[r]),
         .vec   (vec),
         .res   (lane_res[r])
      );
   end

   // combine lanes, buffer the response
   vt4_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (en & p3_valid_ff),
      .lanes       (lane_res),
      .skid_full   (skid_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a full skid entry always sits behind a valid response
   `ASSERT_IMPLIES(a_skid_behind_head, clock, reset, skid_full, rsp_valid)
   // a finished transform always lands in the output register
   `ASSERT_NEXT(a_push_lands, clock, reset, en && p3_valid_ff, rsp_valid)
   // a load shows in the matrix the next cycle
   `ASSERT_NEXT(a_load_written, clock, reset, accept_load,
      matrix_ff[$past(req_payload.elem_index)] == $past(req_payload.elem_value))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 4x4 vertex transform
// -----------------------------------------------------------------------------
// Requests go in through a valid/stall handshake, in bursts with random gaps.
// A local copy of the matrix is updated for every accepted load. Every accepted
// transform is turned into its predicted response right away. Responses are
// taken under a random stall pattern and checked field by field, in order,
// against the oldest predicted response.
// -----------------------------------------------------------------------------
module tb_top;
   import vt4_pkg::*;

   localparam int ACC_W        = 2 * WORD_W + 2;  // four full products never wrap
   localparam int QUIET_LIMIT  = 2000;            // cycles with no handshake at all
   localparam int SETTLE_TICKS = 8;               // pipeline depth plus margin

   // receiver behavior for one stretch of cycles
   typedef enum {FLOW_FREE, FLOW_CHOPPY, FLOW_BLOCKED} flow_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   word_type matrix_elems [ELEMS];   // column-major, element i at row i%4, column i/4
   rsp_type  vertex_results_q [$];   // transformed vertices still owed by the block
   rsp_type  head;
   int       mismatches  = 0;
   int       quiet_count = 0;
   flow_type flow_style  = FLOW_FREE;
   int       flow_left   = 0;

   vertex_transform_4x4 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // matrix-vector product on the local matrix copy
   // ---------------------------------------------------------------------------
   function automatic rsp_type apply_matrix(input word_type vx, vy, vz, vw);
      word_type                vec  [DIM];
      word_type                lane [DIM];
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] top_lim;
      logic signed [ACC_W-1:0] bot_lim;
      logic                    clipped;
      rsp_type                 res;
      vec[0]  = vx;
      vec[1]  = vy;
      vec[2]  = vz;
      vec[3]  = vw;
      top_lim = WORD_MAX;
      bot_lim = WORD_MIN;
      clipped = 1'b0;
      for (int r = 0; r < DIM; r++) begin
         acc = '0;
         // exact sum of four Q32.32 products
         for (int c = 0; c < DIM; c++) begin
            acc = acc + ACC_W'(matrix_elems[r + DIM * c]) * ACC_W'(vec[c]);
         end
         // arithmetic shift gives floor toward minus infinity
         acc = acc >>> FRAC_BITS;
         if (acc > top_lim) begin
            lane[r] = WORD_MAX;
            clipped = 1'b1;
         end else if (acc < bot_lim) begin
            lane[r] = WORD_MIN;
            clipped = 1'b1;
         end else begin
            lane[r] = acc[WORD_W-1:0];
         end
      end
      res.out_x     = lane[0];
      res.out_y     = lane[1];
      res.out_z     = lane[2];
      res.out_w     = lane[3];
      res.saturated = clipped;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // request builders; fields the mode ignores get random junk
   // ---------------------------------------------------------------------------
   function automatic req_type make_load(input logic [IDX_W-1:0] idx, input word_type value);
      req_type item;
      item.mode       = MODE_LOAD;
      item.elem_index = idx;
      item.elem_value = value;
      item.vec_x      = $urandom;
      item.vec_y      = $urandom;
      item.vec_z      = $urandom;
      item.vec_w      = $urandom;
      return item;
   endfunction

   function automatic req_type make_xform(input word_type vx, vy, vz, vw);
      req_type item;
      item.mode       = MODE_XFORM;
      item.elem_index = IDX_W'($urandom);
      item.elem_value = $urandom;
      item.vec_x      = vx;
      item.vec_y      = vy;
      item.vec_z      = vz;
      item.vec_w      = vw;
      return item;
   endfunction

   // mostly moderate magnitudes so only some transforms clip
   function automatic word_type random_word();
      word_type w;
      case ($urandom_range(0, 9))
         0:       w = WORD_MAX;
         1:       w = WORD_MIN;
         2:       w = '0;
         3:       w = $urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16;
         4, 5:    w = $urandom;
         6:       w = word_type'($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
         default: w = word_type'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      endcase
      return w;
   endfunction

   function automatic req_type random_request();
      if ($urandom_range(0, 3) == 0) begin
         return make_load(IDX_W'($urandom_range(0, ELEMS - 1)), random_word());
      end
      return make_xform(random_word(), random_word(), random_word(), random_word());
   endfunction

   // ---------------------------------------------------------------------------
   // request side: drive on the falling edge, watch stall on the rising edge
   // ---------------------------------------------------------------------------
   task automatic send_request(input req_type item);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      // accepted: a load changes the matrix, a transform sees it as it stands now
      if (item.mode == MODE_LOAD) begin
         matrix_elems[item.elem_index] = item.elem_value;
      end else begin
         vertex_results_q.push_back(apply_matrix(item.vec_x, item.vec_y,
                                                 item.vec_z, item.vec_w));
      end
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) @(negedge clock) req_valid <= 1'b0;
   endtask

   // stop sending until the block has handed back every transform
   task automatic drain_results();
      hold_off(1);
      while (vertex_results_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // response side: stall pattern of its own, changes on the falling edge
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (flow_left == 0) begin
         case ($urandom_range(0, 2))
            0: begin
               flow_style = FLOW_FREE;
               flow_left  = $urandom_range(5, 60);
            end
            1: begin
               flow_style = FLOW_CHOPPY;
               flow_left  = 30;
            end
            default: begin
               flow_style = FLOW_BLOCKED;
               flow_left  = $urandom_range(1, 12);
            end
         endcase
      end
      flow_left = flow_left - 1;
      case (flow_style)
         FLOW_FREE:   rsp_stall <= 1'b0;
         FLOW_CHOPPY: rsp_stall <= ($urandom_range(0, 9) < 4);
         default:     rsp_stall <= 1'b1;
      endcase
   end

   function automatic void check_word(input string name, input word_type want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // every accepted response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vertex_results_q.size() == 0) begin
            $display("%0t: response with no transform outstanding, expected none, actual %h",
                     $time, rsp_payload);
            mismatches++;
         end else begin
            head = vertex_results_q.pop_front();
            check_word("out_x", head.out_x, rsp_payload.out_x);
            check_word("out_y", head.out_y, rsp_payload.out_y);
            check_word("out_z", head.out_z, rsp_payload.out_z);
            check_word("out_w", head.out_w, rsp_payload.out_w);
            if (head.saturated !== rsp_payload.saturated) begin
               $display("%0t: saturated mismatch, expected %b, actual %b",
                        $time, head.saturated, rsp_payload.saturated);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any handshake on either side means a hang
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // identity after reset passes vectors through untouched
   task automatic test_identity_passthrough();
      send_request(make_xform(WORD_MAX, WORD_MIN, '0, -32'sd1));
      send_request(make_xform(32'sd1, ONE_Q16, -ONE_Q16, 32'sh0000_7FFF));
      send_request(make_xform(WORD_MIN, WORD_MAX, 32'sh5555_5555, 32'shAAAA_AAAA));
   endtask

   // extreme elements on the diagonal: clipping both ways and floor rounding
   task automatic test_saturation_and_floor();
      send_request(make_load(4'd0, WORD_MAX));
      send_request(make_load(4'd5, WORD_MIN));
      send_request(make_load(4'd10, -32'sd1));
      send_request(make_load(4'd15, 32'sh0000_8000));   // one half
      send_request(make_xform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      send_request(make_xform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      // smallest negative step: half of it must round down, not toward zero
      send_request(make_xform(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
      send_request(make_xform(32'sd1, 32'sd1, 32'sd1, 32'sd1));
   endtask

   // off-diagonal elements check the column-major element order
   task automatic test_column_order();
      send_request(make_load(4'd4, 32'sh0002_0000));    // row 0, column 1
      send_request(make_load(4'd13, -ONE_Q16));         // row 1, column 3
      send_request(make_xform('0, ONE_Q16, '0, ONE_Q16));
   endtask

   // mixed loads and transforms in bursts with random gaps
   task automatic test_random_stream(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_request(random_request());
            sent++;
         end
         // a good share of bursts run straight into the next one
         hold_off(($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15));
      end
   endtask

   // fill the output side, then wait for every response before going on
   task automatic test_drain_pause();
      for (int k = 0; k < 24; k++) begin
         send_request(make_xform(random_word(), random_word(), random_word(), random_word()));
      end
      drain_results();
      for (int k = 0; k < 8; k++) begin
         send_request(random_request());
      end
   endtask

   initial begin
      for (int i = 0; i < ELEMS; i++) begin
         matrix_elems[i] = (i % (DIM + 1) == 0) ? ONE_Q16 : '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_identity_passthrough();
      test_saturation_and_floor();
      test_column_order();
      test_random_stream(350);
      test_drain_pause();
      test_random_stream(380);

      drain_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatches == 0 && vertex_results_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
